/* src/nvt_pkg.sv */
// nvt_pkg: shared sizes, payload types, ram control struct and name normalising function
// for the named variable table; no dependencies
package nvt_pkg;

    localparam int ENTRIES    = 64;
    localparam int NAME_BYTES = 7;
    localparam int NAME_W     = 8 * NAME_BYTES;
    localparam int VALUE_W    = 32;
    localparam int IDX_W      = $clog2(ENTRIES);
    localparam int CNT_W      = $clog2(ENTRIES + 1);

    typedef logic [NAME_W-1:0]         name_t;
    typedef logic signed [VALUE_W-1:0] value_t;
    typedef logic [IDX_W-1:0]          idx_t;
    typedef logic [CNT_W-1:0]          cnt_t;

    typedef enum logic {
        REQ_READ  = 1'b0,
        REQ_WRITE = 1'b1
    } req_type_t;

    typedef struct packed {
        req_type_t req_type;
        name_t     name;
        value_t    wval;
    } req_t;

    typedef struct packed {
        value_t read_value;
        logic   hit;
        logic   stored;
    } res_t;

    typedef struct packed {
        logic we;
        idx_t waddr;
        idx_t raddr;
    } ram_ctl_t;

    // name ends at its first zero byte
    function automatic name_t normalize_name(input name_t raw);
        name_t norm;
        logic  ended;
        norm  = '0;
        ended = 1'b0;
        for (int b = 0; b < NAME_BYTES; b++) begin
            if (raw[8*b +: 8] == 8'd0) begin
                ended = 1'b1;
            end
            if (!ended) begin
                norm[8*b +: 8] = raw[8*b +: 8];
            end
        end
        return norm;
    endfunction

endpackage

/* src/named_variable_table.sv */
// named_variable_table: 64 entry named variable table, read or write by name
// an empty name goes straight to the response; others scan the name ram at one entry per cycle
// to a match or the table end, a hit then writes or reads the value ram, a write miss fills a
// free slot, and the result is registered to m_valid; one transaction in flight, the next taken
// as m_valid rises; a result still held in the output register stalls the finished one
// reset: synchronous active low, all slot valid flags cleared at once, no clearing pass
// depends on nvt_pkg, nvt_ram, nvt_ctrl
module named_variable_table import nvt_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_req_type,
    input  logic [NAME_W-1:0]   s_var_name,
    input  logic signed [VALUE_W-1:0] s_write_value,
    output logic                m_valid,
    input  logic                m_ready,
    output logic signed [VALUE_W-1:0] m_read_value,
    output logic                m_hit,
    output logic                m_stored
);

    req_t     req;
    res_t     res;
    logic     res_valid;
    logic     out_free;
    ram_ctl_t name_ctl;
    ram_ctl_t value_ctl;
    name_t    name_wdata, name_rdata;
    value_t   value_wdata, value_rdata;

    logic     m_valid_reg, m_valid_next;
    res_t     m_res_reg;

    assign req = '{req_type: req_type_t'(s_req_type),
                   name:     normalize_name(s_var_name),
                   wval:     s_write_value};

    assign out_free = !m_valid_reg || m_ready;

    nvt_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .req_valid   (s_valid),
        .req         (req),
        .req_ready   (s_ready),
        .out_free    (out_free),
        .res_valid   (res_valid),
        .res         (res),
        .name_ctl    (name_ctl),
        .name_wdata  (name_wdata),
        .name_rdata  (name_rdata),
        .value_ctl   (value_ctl),
        .value_wdata (value_wdata),
        .value_rdata (value_rdata)
    );

    nvt_ram #(
        .WIDTH (NAME_W),
        .DEPTH (ENTRIES)
    ) u_name_ram (
        .aclk  (aclk),
        .we    (name_ctl.we),
        .waddr (name_ctl.waddr),
        .wdata (name_wdata),
        .raddr (name_ctl.raddr),
        .rdata (name_rdata)
    );

    nvt_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (ENTRIES)
    ) u_value_ram (
        .aclk  (aclk),
        .we    (value_ctl.we),
        .waddr (value_ctl.waddr),
        .wdata (value_wdata),
        .raddr (value_ctl.raddr),
        .rdata (value_rdata)
    );

    // output register
    always_comb begin
        m_valid_next = m_valid_reg;
        if (res_valid) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid) begin
            m_res_reg <= res;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_read_value = m_res_reg.read_value;
    assign m_hit        = m_res_reg.hit;
    assign m_stored     = m_res_reg.stored;

endmodule

/* src/nvt_ram.sv */
// nvt_ram: generic single write port, single read port synchronous ram
// with registered read data; no dependencies
module nvt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* src/nvt_ctrl.sv */
// nvt_ctrl: lookup sequencer with slot valid flags; scans the name ram one entry per cycle,
// finds match and first free slot, then reads or writes the value ram (a read miss skips it); uses nvt_pkg
module nvt_ctrl import nvt_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     req_valid,
    input  req_t     req,
    output logic     req_ready,
    input  logic     out_free,
    output logic     res_valid,
    output res_t     res,
    output ram_ctl_t name_ctl,
    output name_t    name_wdata,
    input  name_t    name_rdata,
    output ram_ctl_t value_ctl,
    output value_t   value_wdata,
    input  value_t   value_rdata
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SCAN  = 4'b0010,
        ST_FETCH = 4'b0100,
        ST_RESP  = 4'b1000
    } state_t;

    state_t               state_reg, state_next;
    logic [ENTRIES-1:0]   valid_reg, valid_next;
    logic                 pend_reg, pend_next;
    logic                 pend_valid_reg, pend_valid_next;
    idx_t                 pend_idx_reg, pend_idx_next;
    logic                 free_found_reg, free_found_next;
    idx_t                 free_idx_reg, free_idx_next;
    cnt_t                 cnt_reg, cnt_next;
    req_t                 req_reg, req_next;
    res_t                 res_reg, res_next;

    logic issue;
    idx_t cur_idx;
    logic cur_valid;
    logic match;

    always_comb begin
        state_next      = state_reg;
        valid_next      = valid_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        pend_idx_next   = pend_idx_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        cnt_next        = cnt_reg;
        req_next        = req_reg;
        res_next        = res_reg;

        issue     = (cnt_reg != CNT_W'(ENTRIES));
        cur_idx   = cnt_reg[IDX_W-1:0];
        cur_valid = valid_reg[cur_idx];
        match     = pend_reg && pend_valid_reg && (name_rdata == req_reg.name);

        name_ctl.we     = 1'b0;
        name_ctl.waddr  = free_idx_reg;
        name_ctl.raddr  = cur_idx;
        name_wdata      = req_reg.name;
        value_ctl.we    = 1'b0;
        value_ctl.waddr = free_idx_reg;
        value_ctl.raddr = pend_idx_reg;
        value_wdata     = req_reg.wval;

        req_ready = (state_reg == ST_IDLE);
        res_valid = 1'b0;
        res       = res_reg;

        case (state_reg)
            ST_IDLE: begin
                if (req_valid) begin
                    req_next        = req;
                    res_next        = '0;
                    cnt_next        = '0;
                    pend_next       = 1'b0;
                    free_found_next = 1'b0;
                    // empty name never matches
                    state_next      = (req.name == '0) ? ST_RESP : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (issue) begin
                    cnt_next        = cnt_reg + CNT_W'(1);
                    pend_next       = 1'b1;
                    pend_idx_next   = cur_idx;
                    pend_valid_next = cur_valid;
                    if (!cur_valid && !free_found_reg) begin
                        free_found_next = 1'b1;
                        free_idx_next   = cur_idx;
                    end
                end else begin
                    pend_next = 1'b0;
                end
                if (match) begin
                    res_next.hit = 1'b1;
                    if (req_reg.req_type == REQ_WRITE) begin
                        value_ctl.we    = 1'b1;
                        value_ctl.waddr = pend_idx_reg;
                        res_next.stored = 1'b1;
                        state_next      = ST_RESP;
                    end else begin
                        state_next = ST_FETCH;
                    end
                end else if (!issue && !pend_reg) begin
                    if (req_reg.req_type == REQ_WRITE && free_found_reg) begin
                        name_ctl.we             = 1'b1;
                        value_ctl.we            = 1'b1;
                        valid_next[free_idx_reg] = 1'b1;
                        res_next.stored         = 1'b1;
                    end
                    state_next = ST_RESP;
                end
            end
            ST_FETCH: begin
                res_next.read_value = value_rdata;
                state_next          = ST_RESP;
            end
            ST_RESP: begin
                if (out_free) begin
                    res_valid  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            valid_reg      <= '0;
            pend_reg       <= 1'b0;
            free_found_reg <= 1'b0;
            cnt_reg        <= '0;
        end else begin
            state_reg      <= state_next;
            valid_reg      <= valid_next;
            pend_reg       <= pend_next;
            free_found_reg <= free_found_next;
            cnt_reg        <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        pend_valid_reg <= pend_valid_next;
        pend_idx_reg   <= pend_idx_next;
        free_idx_reg   <= free_idx_next;
        req_reg        <= req_next;
        res_reg        <= res_next;
    end

endmodule

/* src/nvt_checker.sv */
// nvt_checker: port level checks for named_variable_table, bound to the top level
// depends on nvt_pkg
module nvt_checker import nvt_pkg::*; (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                s_req_type,
    input logic [NAME_W-1:0]   s_var_name,
    input logic signed [VALUE_W-1:0] s_write_value,
    input logic                m_valid,
    input logic                m_ready,
    input logic signed [VALUE_W-1:0] m_read_value,
    input logic                m_hit,
    input logic                m_stored
);

    // no result straight after reset
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // a stalled result is held
    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_read_value))
        else $error("stalled result dropped or changed");

    // one transaction in flight
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second transaction taken while busy");

    // a non-zero value only comes from a read hit
    a_value_needs_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_read_value != '0) |-> m_hit && !m_stored)
        else $error("read value without read hit");

endmodule

bind named_variable_table nvt_checker u_nvt_checker (.*);
